>>> src/rtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_pkg
// Shared types, codes and constants of the response terminator matcher.
// ----------------------------------------------------------------------------
package rtm_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_CAPTURE_BYTES   = 32;
    localparam int DEF_MAX_TERM_LENGTH = 4;

    // Command codes of an input transaction.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_TERM_A_BYTES  = 3'd0;
    localparam logic [2:0] REG_TERM_A_LENGTH = 3'd1;
    localparam logic [2:0] REG_TERM_B_BYTES  = 3'd2;
    localparam logic [2:0] REG_TERM_B_LENGTH = 3'd3;
    localparam logic [2:0] REG_TERM_COUNT    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd5;

    // Register reset values: ">J\n" and "\n!J\n".
    localparam logic [31:0] RST_TERM_A_BYTES  = 32'd674366;
    localparam logic [2:0]  RST_TERM_A_LENGTH = 3'd3;
    localparam logic [31:0] RST_TERM_B_BYTES  = 32'd172630282;
    localparam logic [2:0]  RST_TERM_B_LENGTH = 3'd4;
    localparam logic [1:0]  RST_TERM_COUNT    = 2'd2;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd100;

    // Characters seen by the decimal parser.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Result status codes.
    localparam logic STATUS_MATCH   = 1'b0;
    localparam logic STATUS_TIMEOUT = 1'b1;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    // Payload of an input transaction.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } rtm_in_t;

    // Payload of a result transaction.
    typedef struct packed {
        logic               status;
        logic               which_terminator;
        logic               number_found;
        logic signed [31:0] parsed_value;
        logic [5:0]         bytes_captured;
    } rtm_out_t;

    // Next index and completion flag of one terminator pattern.
    typedef struct packed {
        logic [2:0] index;
        logic       hit;
    } rtm_match_t;

    // State of the decimal parser.
    typedef struct packed {
        logic        started;
        logic        negative;
        logic        stopped;
        logic [31:0] acc;
    } rtm_parse_t;

endpackage

>>> src/rtm_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rtm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input ready, input payload);
endinterface

>>> src/rtm_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_matcher
// Naive compare of one received byte against one terminator pattern.
// ----------------------------------------------------------------------------
module rtm_matcher
    import rtm_pkg::*;
#(
    parameter int MAX_TERM_LENGTH = DEF_MAX_TERM_LENGTH
) (
    input  logic [2:0]  index,
    input  logic [31:0] term_bytes,
    input  logic [2:0]  term_length,
    input  logic [7:0]  rx_byte,
    output rtm_match_t  match
);
    localparam logic [3:0] MAX_LEN = 4'(MAX_TERM_LENGTH);

    logic [3:0] len;
    logic [7:0] expected;
    logic [3:0] index_inc;

    // Clamp the length and pick the expected character.
    always_comb
    begin
        len       = ({1'b0, term_length} > MAX_LEN) ? MAX_LEN : {1'b0, term_length};
        expected  = index[2] ? 8'h00 : term_bytes[{index[1:0], 3'b000} +: 8];
        index_inc = {1'b0, index} + 4'd1;
    end

    // Advance on a matching character, fall back to zero on anything else.
    always_comb
    begin
        match.index = 3'd0;
        match.hit   = 1'b0;
        if ((len != 4'd0) && ({1'b0, index} < len) && (rx_byte == expected))
        begin
            match.index = index_inc[2:0];
            match.hit   = (index_inc == len);
        end
    end
endmodule

>>> src/rtm_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_parser
// One step of the signed decimal parser over a captured byte.
// ----------------------------------------------------------------------------
module rtm_parser
    import rtm_pkg::*;
(
    input  rtm_parse_t state,
    input  logic [7:0] rx_byte,
    output rtm_parse_t state_next
);
    logic        is_digit;
    logic [31:0] acc_times_ten;

    // Multiply by ten as two shifts and an add; the sum wraps in 32 bits.
    always_comb
    begin
        is_digit      = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
        acc_times_ten = {state.acc[28:0], 3'b000} + {state.acc[30:0], 1'b0};
    end

    // Sign, digits and the end of the number.
    always_comb
    begin
        state_next = state;
        priority if (state.stopped)
        begin
            state_next = state;
        end
        else if (rx_byte == CHAR_NUL)
        begin
            state_next.stopped = 1'b1;
        end
        else if (!state.started && (rx_byte == CHAR_MINUS))
        begin
            state_next.negative = 1'b1;
            state_next.started  = 1'b1;
        end
        else if (is_digit)
        begin
            state_next.started = 1'b1;
            state_next.acc     = acc_times_ten + {28'd0, rx_byte[3:0]};
        end
        else if (state.started)
        begin
            state_next.stopped = 1'b1;
        end
        else
        begin
            state_next = state;
        end
    end
endmodule

>>> src/response_terminator_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_terminator_matcher_top
// Waits for one of two terminator strings or a tick timeout and reports the
// first signed decimal number found in the captured response.
//
// Channel   Dir   Payload                                      Handshake
// item      in    command, rx_byte                             valid/ready
// result    out   status, which_terminator, number_found,      valid/ready
//                 parsed_value, bytes_captured
// cfg       in    cfg_index, cfg_data                          cfg_write
//
// An accepted transaction is held in the input register and processed from
// there, which also loads the result register when a result is due; the
// result is then offered from the result register. One transaction per cycle
// is sustained; the input is held only while a result waits in the result
// register and the result side is not ready.
// Reset clears all control state and loads the register reset values.
// ----------------------------------------------------------------------------
module response_terminator_matcher_top
    import rtm_pkg::*;
#(
    parameter int CAPTURE_BYTES   = DEF_CAPTURE_BYTES,
    parameter int MAX_TERM_LENGTH = DEF_MAX_TERM_LENGTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rtm_stream_if.sink           item,
    rtm_stream_if.source         result,
    input  logic                 cfg_write,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);
    localparam int CAP_W = $clog2(CAPTURE_BYTES + 1);
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CAPTURE_BYTES);

    // Configuration registers.
    logic [31:0] term_a_bytes_reg;
    logic [2:0]  term_a_length_reg;
    logic [31:0] term_b_bytes_reg;
    logic [2:0]  term_b_length_reg;
    logic [1:0]  term_count_reg;
    logic [15:0] timeout_ticks_reg;

    // Input register.
    logic    item_valid_reg;
    rtm_in_t item_reg;

    // Wait state.
    logic             armed_reg, armed_next;
    logic [2:0]       index_a_reg, index_a_next;
    logic [2:0]       index_b_reg, index_b_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic [CAP_W-1:0] capture_reg, capture_next;
    rtm_parse_t       parse_reg, parse_next;

    // Result register.
    logic     result_valid_reg, result_valid_next;
    rtm_out_t result_reg, result_next;

    rtm_match_t       match_a;
    rtm_match_t       match_b;
    rtm_parse_t       parse_step;
    logic             process;
    logic             emit;
    logic             emit_status;
    logic             emit_which;
    logic [CAP_W+5:0] capture_wide;

    // The held transaction moves on unless a waiting result blocks the slot.
    assign process    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || process;

    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    rtm_matcher #(
        .MAX_TERM_LENGTH(MAX_TERM_LENGTH)
    ) u_matcher_a (
        .index       (index_a_reg),
        .term_bytes  (term_a_bytes_reg),
        .term_length (term_a_length_reg),
        .rx_byte     (item_reg.rx_byte),
        .match       (match_a)
    );

    rtm_matcher #(
        .MAX_TERM_LENGTH(MAX_TERM_LENGTH)
    ) u_matcher_b (
        .index       (index_b_reg),
        .term_bytes  (term_b_bytes_reg),
        .term_length (term_b_length_reg),
        .rx_byte     (item_reg.rx_byte),
        .match       (match_b)
    );

    rtm_parser u_parser (
        .state      (parse_reg),
        .rx_byte    (item_reg.rx_byte),
        .state_next (parse_step)
    );

    // Command decode, match, timeout and result build.
    always_comb
    begin
        armed_next   = armed_reg;
        index_a_next = index_a_reg;
        index_b_next = index_b_reg;
        elapsed_next = elapsed_reg;
        capture_next = capture_reg;
        parse_next   = parse_reg;
        emit         = 1'b0;
        emit_status  = STATUS_MATCH;
        emit_which   = 1'b0;

        if (item_reg.command == CMD_START)
        begin
            armed_next   = 1'b1;
            index_a_next = 3'd0;
            index_b_next = 3'd0;
            elapsed_next = 16'd0;
            capture_next = '0;
            parse_next   = '0;
        end
        else if (armed_reg && (item_reg.command == CMD_BYTE))
        begin
            if (capture_reg < CAP_LIMIT)
            begin
                capture_next = capture_reg + CAP_W'(1);
                parse_next   = parse_step;
            end
            if (term_count_reg != 2'd0)
            begin
                index_a_next = match_a.index;
            end
            if ((term_count_reg != 2'd0) && match_a.hit)
            begin
                emit = 1'b1;
            end
            else
            begin
                // Second pattern only looks at the byte when the first did not end.
                if (term_count_reg[1])
                begin
                    index_b_next = match_b.index;
                end
                if (term_count_reg[1] && match_b.hit)
                begin
                    emit       = 1'b1;
                    emit_which = 1'b1;
                end
                else if (elapsed_reg >= timeout_ticks_reg)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_TIMEOUT;
                end
            end
        end
        else if (armed_reg && (item_reg.command == CMD_TICK))
        begin
            if (elapsed_reg != TICKS_MAX)
            begin
                elapsed_next = elapsed_reg + 16'd1;
            end
            if (elapsed_next >= timeout_ticks_reg)
            begin
                emit        = 1'b1;
                emit_status = STATUS_TIMEOUT;
            end
        end

        if (emit)
        begin
            armed_next = 1'b0;
        end

        capture_wide                   = {6'd0, capture_next};
        result_next.status             = emit_status;
        result_next.which_terminator   = emit_which;
        result_next.number_found       = parse_next.started;
        result_next.parsed_value       = parse_next.negative ? (32'd0 - parse_next.acc)
                                                             : parse_next.acc;
        result_next.bytes_captured     = capture_wide[5:0];
    end

    // Result valid: set by a new result, cleared when taken.
    always_comb
    begin
        priority if (process && emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_a_bytes_reg  <= RST_TERM_A_BYTES;
            term_a_length_reg <= RST_TERM_A_LENGTH;
            term_b_bytes_reg  <= RST_TERM_B_BYTES;
            term_b_length_reg <= RST_TERM_B_LENGTH;
            term_count_reg    <= RST_TERM_COUNT;
            timeout_ticks_reg <= RST_TIMEOUT_TICKS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TERM_A_BYTES:  term_a_bytes_reg  <= cfg_data;
                REG_TERM_A_LENGTH: term_a_length_reg <= cfg_data[2:0];
                REG_TERM_B_BYTES:  term_b_bytes_reg  <= cfg_data;
                REG_TERM_B_LENGTH: term_b_length_reg <= cfg_data[2:0];
                REG_TERM_COUNT:    term_count_reg    <= cfg_data[1:0];
                REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[15:0];
                default:           term_count_reg    <= term_count_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.payload;
        end
    end

    // Wait state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            index_a_reg      <= 3'd0;
            index_b_reg      <= 3'd0;
            elapsed_reg      <= 16'd0;
            capture_reg      <= '0;
            parse_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (process)
            begin
                armed_reg   <= armed_next;
                index_a_reg <= index_a_next;
                index_b_reg <= index_b_next;
                elapsed_reg <= elapsed_next;
                capture_reg <= capture_next;
                parse_reg   <= parse_next;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            result_reg <= result_next;
        end
    end
endmodule

>>> src/rtm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtm_checker
// Port-level assertions on the response terminator matcher.
// ----------------------------------------------------------------------------
module rtm_checker
    import rtm_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    rtm_stream_if.sink   item,
    rtm_stream_if.source result
);
    // A waiting result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid)
        else $error("result valid dropped while stalled");

    // A waiting result keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> $stable(result.payload))
        else $error("result payload changed while stalled");

    // A new result traces back to a transaction accepted into the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(item.valid && item.ready, 2))
        else $error("result appeared without a recent input transaction");

    // The input is held back only by a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready))
        else $error("input stalled while the result side was free");
endmodule

bind response_terminator_matcher_top rtm_checker u_rtm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (item),
    .result (result)
);
